### hdl/dtsl_pkg.sv
// ----------------------------------------------------------------------------
// dtsl_pkg
// Shared types, codes and character helpers of the track sheet line parser.
// ----------------------------------------------------------------------------
package dtsl_pkg;

  // default sizes
  localparam int MAX_TRACKS_DEF      = 99;
  localparam int NAME_CAPACITY_DEF   = 32;
  localparam int MAX_SHEET_BYTES_DEF = 4096;

  // configuration port
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_SECTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME  = 2'd1;
  localparam logic [15:0] RAW_SECTOR_RST = 16'd2352;
  localparam logic [23:0] MAX_FRAME_RST  = 24'd549150;

  // address arithmetic
  localparam logic [32:0] LBA_BIAS      = 33'd150;
  localparam logic [31:0] HIGH_AREA_LBA = 32'd45000;

  // result kinds
  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_TRACK   = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // error codes
  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_COUNT    = 4'd1;
  localparam logic [3:0] ERR_TRACK    = 4'd2;
  localparam logic [3:0] ERR_ADDR     = 4'd3;
  localparam logic [3:0] ERR_CTRL     = 4'd4;
  localparam logic [3:0] ERR_SECTOR   = 4'd5;
  localparam logic [3:0] ERR_NAME     = 4'd6;
  localparam logic [3:0] ERR_OFFSET   = 4'd7;
  localparam logic [3:0] ERR_ORDER    = 4'd8;
  localparam logic [3:0] ERR_DUP      = 4'd9;
  localparam logic [3:0] ERR_EXTRA    = 4'd10;
  localparam logic [3:0] ERR_MISSING  = 4'd11;
  localparam logic [3:0] ERR_OVERFLOW = 4'd12;

  // field positions within a line
  localparam logic [2:0] FP_COUNT  = 3'd0;
  localparam logic [2:0] FP_TRACK  = 3'd1;
  localparam logic [2:0] FP_ADDR   = 3'd2;
  localparam logic [2:0] FP_CTRL   = 3'd3;
  localparam logic [2:0] FP_SECTOR = 3'd4;
  localparam logic [2:0] FP_NAME   = 3'd5;
  localparam logic [2:0] FP_OFFSET = 3'd6;
  localparam logic [2:0] FP_TAIL   = 3'd7;

  // token phases
  localparam logic [1:0] TP_IDLE   = 2'd0;
  localparam logic [1:0] TP_IN     = 2'd1;
  localparam logic [1:0] TP_CLOSED = 2'd2;

  // characters
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PRE, ST_CHAR, ST_LINE, ST_FIN,
    ST_WLEN, ST_WLCHK, ST_WCHR, ST_WCMP, ST_VERDICT
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_ACCEPT, CMD_PRE, CMD_CHAR, CMD_LINE, CMD_WNEXT,
    CMD_WCHR, CMD_WKINC, CMD_WEND_OK, CMD_WEND_DUP, CMD_VERDICT
  } cmd_t;

  typedef enum logic [1:0] {RT_DONE, RT_CHAR, RT_LINE} route_t;

  typedef struct packed {
    cmd_t cmd;
    logic walk_line;
  } ctrl_t;

  typedef struct packed {
    route_t route;
    logic   char_walk;
    logic   line_walk;
    logic   walk_at_idx;
    logic   len_match;
    logic   chr_match;
    logic   chr_last;
    logic   err_none;
    logic   last;
    logic   byte_nl;
    logic   slot_free;
  } stat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_char;
    logic [6:0]  track_number;
    logic [2:0]  control_bits;
    logic        session_high;
    logic [23:0] start_frame;
    logic        sheet_ok;
    logic [3:0]  error_code;
    logic        last;
  } res_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_forbidden(input logic [7:0] c);
    return (c == 8'h5C) || (c == 8'h2F) || (c == 8'h3A) || (c == 8'h2A) ||
           (c == 8'h3F) || (c == 8'h22) || (c == 8'h3C) || (c == 8'h3E) ||
           (c == 8'h7C);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'd32) : c;
  endfunction

endpackage

### hdl/dtsl_in_if.sv
// ----------------------------------------------------------------------------
// dtsl_in_if
// Byte channel into the parser: one sheet byte and its final-byte mark.
// ----------------------------------------------------------------------------
interface dtsl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

### hdl/dtsl_out_if.sv
// ----------------------------------------------------------------------------
// dtsl_out_if
// Result channel out of the parser: name characters, track records, verdict.
// ----------------------------------------------------------------------------
interface dtsl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  name_char;
  logic [6:0]  track_number;
  logic [2:0]  control_bits;
  logic        session_high;
  logic [23:0] start_frame;
  logic        sheet_ok;
  logic [3:0]  error_code;
  logic        last;

  modport source(output valid, output kind, output name_char, output track_number,
                 output control_bits, output session_high, output start_frame,
                 output sheet_ok, output error_code, output last, input ready);
  modport sink(input valid, input kind, input name_char, input track_number,
               input control_bits, input session_high, input start_frame,
               input sheet_ok, input error_code, input last, output ready);
endinterface

### hdl/dtsl_ctrl.sv
// ----------------------------------------------------------------------------
// dtsl_ctrl
// Sequencer: steps each byte through check, character, line end, name
// duplicate walk and verdict, issuing at most one datapath command per cycle.
// ----------------------------------------------------------------------------
module dtsl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dtsl_pkg::stat_t stat,
  output dtsl_pkg::ctrl_t ctrl
);
  import dtsl_pkg::*;

  state_t state, state_next;
  logic   walk_line, walk_line_next;
  logic   tail, tail_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      walk_line <= 1'b0;
      tail      <= 1'b0;
    end else begin
      state     <= state_next;
      walk_line <= walk_line_next;
      tail      <= tail_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    walk_line_next = walk_line;
    tail_next      = tail;
    in_ready       = 1'b0;
    ctrl.cmd       = CMD_NONE;
    ctrl.walk_line = walk_line;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.cmd   = CMD_ACCEPT;
          tail_next  = 1'b0;
          state_next = ST_PRE;
        end
      end
      ST_PRE: begin
        ctrl.cmd = CMD_PRE;
        unique case (stat.route)
          RT_CHAR: state_next = ST_CHAR;
          RT_LINE: state_next = ST_LINE;
          default: state_next = ST_FIN;
        endcase
      end
      ST_CHAR: begin
        if (stat.slot_free) begin
          ctrl.cmd       = CMD_CHAR;
          walk_line_next = 1'b0;
          state_next     = stat.char_walk ? ST_WLEN : ST_FIN;
        end
      end
      ST_LINE: begin
        if (stat.slot_free) begin
          ctrl.cmd       = CMD_LINE;
          walk_line_next = 1'b1;
          state_next     = stat.line_walk ? ST_WLEN : ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat.last && !tail && stat.err_none && !stat.byte_nl) begin
          tail_next  = 1'b1;
          state_next = ST_LINE;
        end else if (stat.last) begin
          state_next = ST_VERDICT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_WLEN: begin
        if (stat.walk_at_idx) begin
          ctrl.cmd   = CMD_WEND_OK;
          state_next = ST_FIN;
        end else begin
          state_next = ST_WLCHK;
        end
      end
      ST_WLCHK: begin
        if (stat.len_match) begin
          ctrl.cmd   = CMD_WCHR;
          state_next = ST_WCHR;
        end else begin
          ctrl.cmd   = CMD_WNEXT;
          state_next = ST_WLEN;
        end
      end
      ST_WCHR: state_next = ST_WCMP;
      ST_WCMP: begin
        if (!stat.chr_match) begin
          ctrl.cmd   = CMD_WNEXT;
          state_next = ST_WLEN;
        end else if (stat.chr_last) begin
          ctrl.cmd   = CMD_WEND_DUP;
          state_next = ST_FIN;
        end else begin
          ctrl.cmd   = CMD_WKINC;
          state_next = ST_WCHR;
        end
      end
      ST_VERDICT: begin
        if (stat.slot_free) begin
          ctrl.cmd   = CMD_VERDICT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### hdl/dtsl_dp.sv
// ----------------------------------------------------------------------------
// dtsl_dp
// Datapath: parse registers, number checks, name store and name length
// memories, duplicate compare, configuration registers and result register.
// ----------------------------------------------------------------------------
module dtsl_dp #(
  parameter int MAX_TRACKS      = dtsl_pkg::MAX_TRACKS_DEF,
  parameter int NAME_CAPACITY   = dtsl_pkg::NAME_CAPACITY_DEF,
  parameter int MAX_SHEET_BYTES = dtsl_pkg::MAX_SHEET_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dtsl_pkg::ctrl_t                ctrl,
  output dtsl_pkg::stat_t                stat,
  input  logic [7:0]                     data_byte,
  input  logic                           last_byte,
  input  logic                           cfg_we,
  input  logic [dtsl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dtsl_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           res_ready,
  output logic                           res_valid,
  output dtsl_pkg::res_t                 res
);
  import dtsl_pkg::*;

  localparam int NW    = $clog2(NAME_CAPACITY);
  localparam int TW    = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int DEPTH = MAX_TRACKS * (2 ** NW);
  localparam int AW    = TW + NW;
  localparam int BCW   = $clog2(MAX_SHEET_BYTES + 1);

  // configuration
  logic [15:0] raw_sector_bytes;
  logic [23:0] max_frame_address;

  // current byte
  logic [7:0] byte_reg;
  logic       last_reg;

  // parse state
  logic [7:0]     ch, ch_next;
  logic [2:0]     fp, fp_next;
  logic [1:0]     tp, tp_next;
  logic [31:0]    acc, acc_next;
  logic [6:0]     li, li_next;
  logic [6:0]     tc, tc_next;
  logic [23:0]    prev, prev_next;
  logic           quoted, quoted_next;
  logic [3:0]     err, err_next;
  logic [BCW-1:0] bc, bc_next;
  logic [23:0]    cur_start, cur_start_next;
  logic [2:0]     cur_ctl, cur_ctl_next;
  logic           cur_sess, cur_sess_next;
  logic [NW-1:0]  nl, nl_next;
  logic [7:0]     first_c, first_c_next;
  logic [7:0]     last_c, last_c_next;
  logic           crp, crp_next;
  logic           als, als_next;
  logic [6:0]     wi, wi_next;
  logic [NW-1:0]  wk, wk_next;

  // memories
  logic [7:0]    name_store [DEPTH];
  logic [NW-1:0] name_lengths [MAX_TRACKS];
  logic [7:0]    ca_q, cb_q;
  logic [NW-1:0] len_q;
  logic          store_we, lens_we;
  logic [AW-1:0] store_waddr;

  // helpers
  logic [6:0]  idx;
  logic [32:0] s_sum;
  logic [35:0] mul10;
  logic [3:0]  fin_code;
  logic        name_bad, char_do_end, line_do_end, bc_over, extra_line;
  logic [3:0]  pre_err;
  logic        emit;
  res_t        res_next;
  logic [3:0]  fail;
  logic        fin_apply, do_store;
  logic [NW-1:0] nl_eff;
  logic        ok_v;

  assign idx   = li - 7'd1;
  assign s_sum = {1'b0, acc} + LBA_BIAS;
  assign mul10 = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {32'b0, ch[3:0] - 4'd0};

  // completed number checks
  always_comb begin
    fin_code = ERR_NONE;
    case (fp)
      FP_COUNT:
        if (acc == 32'd0 || acc > 32'(MAX_TRACKS)) fin_code = ERR_COUNT;
      FP_TRACK:
        if (acc != {25'b0, li}) fin_code = ERR_TRACK;
      FP_ADDR:
        if (s_sum > {9'b0, max_frame_address}) fin_code = ERR_ADDR;
        else if (li > 7'd1 && s_sum <= {9'b0, prev}) fin_code = ERR_ORDER;
      FP_CTRL:
        if (acc != 32'd0 && acc != 32'd4) fin_code = ERR_CTRL;
      FP_SECTOR:
        if (acc != {16'b0, raw_sector_bytes}) fin_code = ERR_SECTOR;
      default:
        if (acc != 32'd0) fin_code = ERR_OFFSET;
    endcase
  end

  // name end checks
  assign name_bad = (li == 7'd0) || (idx >= 7'(MAX_TRACKS)) || (nl == '0) ||
                    (first_c == CH_DOT) || (last_c == CH_DOT) || (last_c == CH_SP);
  assign char_do_end = (fp == FP_NAME) &&
                       ((tp == TP_CLOSED && is_blank(ch)) ||
                        (tp == TP_IN && !quoted && is_blank(ch)));
  assign line_do_end = (fp == FP_NAME) && ((tp == TP_IN && !quoted) || tp == TP_CLOSED);

  // byte entry checks
  assign bc_over    = bc >= BCW'(MAX_SHEET_BYTES);
  assign extra_line = als && (li >= 7'd1) && (li > tc);
  always_comb begin
    pre_err = err;
    if (pre_err == ERR_NONE && bc_over) pre_err = ERR_EXTRA;
    if (pre_err == ERR_NONE && extra_line) pre_err = ERR_EXTRA;
  end

  // status to the sequencer
  always_comb begin
    if (pre_err != ERR_NONE) stat.route = RT_DONE;
    else if (crp) stat.route = (byte_reg == CH_NL) ? RT_LINE : RT_CHAR;
    else if (byte_reg == CH_NL) stat.route = RT_LINE;
    else if (byte_reg == CH_CR) stat.route = RT_DONE;
    else stat.route = RT_CHAR;
    stat.char_walk   = char_do_end && !name_bad;
    stat.line_walk   = line_do_end && !name_bad;
    stat.walk_at_idx = wi == idx;
    stat.len_match   = len_q == nl;
    stat.chr_match   = fold_case(ca_q) == fold_case(cb_q);
    stat.chr_last    = wk == (nl - NW'(1));
    stat.err_none    = err == ERR_NONE;
    stat.last        = last_reg;
    stat.byte_nl     = byte_reg == CH_NL;
    stat.slot_free   = !res_valid || res_ready;
  end

  // command execution
  always_comb begin
    ch_next = ch; fp_next = fp; tp_next = tp; acc_next = acc; li_next = li;
    tc_next = tc; prev_next = prev; quoted_next = quoted; err_next = err;
    bc_next = bc; cur_start_next = cur_start; cur_ctl_next = cur_ctl;
    cur_sess_next = cur_sess; nl_next = nl; first_c_next = first_c;
    last_c_next = last_c; crp_next = crp; als_next = als; wi_next = wi; wk_next = wk;
    store_we = 1'b0; lens_we = 1'b0; emit = 1'b0; res_next = '0;
    fail = ERR_NONE; fin_apply = 1'b0; do_store = 1'b0; nl_eff = nl; ok_v = 1'b0;
    store_waddr = {idx[TW-1:0], nl};
    unique case (ctrl.cmd)
      CMD_PRE: begin
        err_next = pre_err;
        if (err == ERR_NONE && !bc_over) begin
          bc_next = bc + BCW'(1);
          if (als) als_next = 1'b0;
        end
        if (pre_err == ERR_NONE) begin
          if (crp) begin
            crp_next = 1'b0;
            ch_next  = CH_CR;
          end else begin
            ch_next = byte_reg;
            if (byte_reg == CH_CR) crp_next = 1'b1;
          end
        end
      end
      CMD_CHAR: begin
        if (fp == FP_TAIL) begin
          if (!is_blank(ch)) fail = ERR_EXTRA;
        end else if (fp == FP_NAME) begin
          if (tp == TP_IDLE) begin
            if (!is_blank(ch)) begin
              tp_next = TP_IN;
              nl_next = '0;
              nl_eff  = '0;
              if (ch == CH_QUOTE) quoted_next = 1'b1;
              else begin
                quoted_next = 1'b0;
                do_store    = 1'b1;
              end
            end
          end else if (tp == TP_CLOSED) begin
            if (!is_blank(ch)) fail = ERR_NAME;
          end else if (quoted && ch == CH_QUOTE) begin
            tp_next = TP_CLOSED;
          end else if (quoted || !is_blank(ch)) begin
            do_store = 1'b1;
          end
          // name end starts the duplicate walk
          if (char_do_end) begin
            if (name_bad) fail = ERR_NAME;
            else begin
              lens_we = 1'b1;
              wi_next = 7'd0;
            end
          end
          // store an accepted name character
          if (do_store) begin
            if (ch < 8'd32 || ch > 8'd126 || is_forbidden(ch) ||
                ({1'b0, nl_eff} + (NW+1)'(1)) >= (NW+1)'(NAME_CAPACITY) ||
                li == 7'd0 || idx >= 7'(MAX_TRACKS)) begin
              fail = ERR_NAME;
            end else begin
              store_we    = 1'b1;
              store_waddr = {idx[TW-1:0], nl_eff};
              nl_next     = nl_eff + NW'(1);
              if (nl_eff == '0) first_c_next = ch;
              last_c_next = ch;
              emit = 1'b1;
              res_next.kind      = KIND_CHAR;
              res_next.name_char = ch;
              res_next.last      = !last_reg;
            end
          end
        end else begin
          // number fields
          if (tp == TP_IDLE) begin
            if (is_digit(ch)) begin
              tp_next  = TP_IN;
              acc_next = {28'b0, ch[3:0]};
            end else if (!is_blank(ch)) begin
              fail = {1'b0, fp} + 4'd1;
            end
          end else if (is_digit(ch)) begin
            if (|mul10[35:32]) fail = ERR_OVERFLOW;
            else acc_next = mul10[31:0];
          end else if (is_blank(ch)) begin
            if (fin_code != ERR_NONE) fail = fin_code;
            else begin
              fin_apply = 1'b1;
              fp_next   = (fp == FP_COUNT || fp == FP_OFFSET) ? FP_TAIL : fp + 3'd1;
              tp_next   = TP_IDLE;
              acc_next  = '0;
            end
          end else begin
            fail = {1'b0, fp} + 4'd1;
          end
        end
      end
      CMD_LINE: begin
        als_next = 1'b1;
        if (fp == FP_NAME) begin
          if (line_do_end && !name_bad) begin
            lens_we = 1'b1;
            wi_next = 7'd0;
          end else begin
            fail = ERR_NAME;
          end
        end else begin
          ok_v = 1'b1;
          if (fp != FP_TAIL) begin
            if (tp != TP_IN) begin
              fail = {1'b0, fp} + 4'd1;
              ok_v = 1'b0;
            end else if (fin_code != ERR_NONE) begin
              fail = fin_code;
              ok_v = 1'b0;
            end else begin
              fin_apply = 1'b1;
              if (fp != FP_COUNT && fp != FP_OFFSET) begin
                fail = {1'b0, fp} + 4'd2;
                ok_v = 1'b0;
              end
            end
          end
          // line complete
          if (ok_v) begin
            if (li >= 7'd1) begin
              emit = 1'b1;
              res_next.kind         = KIND_TRACK;
              res_next.track_number = li;
              res_next.control_bits = cur_ctl;
              res_next.session_high = cur_sess;
              res_next.start_frame  = cur_start;
              res_next.last         = !last_reg;
              prev_next = cur_start;
            end
            if (li < 7'd127) li_next = li + 7'd1;
            fp_next     = FP_TRACK;
            tp_next     = TP_IDLE;
            acc_next    = '0;
            quoted_next = 1'b0;
          end
        end
      end
      CMD_WNEXT: wi_next = wi + 7'd1;
      CMD_WCHR:  wk_next = '0;
      CMD_WKINC: wk_next = wk + NW'(1);
      CMD_WEND_OK: begin
        if (ctrl.walk_line) fail = ERR_OFFSET;
        else begin
          fp_next  = FP_OFFSET;
          tp_next  = TP_IDLE;
          acc_next = '0;
        end
      end
      CMD_WEND_DUP: fail = ERR_DUP;
      CMD_VERDICT: begin
        emit = 1'b1;
        res_next.kind = KIND_VERDICT;
        res_next.sheet_ok = (err == ERR_NONE) && ({1'b0, li} == ({1'b0, tc} + 8'd1));
        if (err != ERR_NONE) res_next.error_code = err;
        else if (!res_next.sheet_ok) res_next.error_code = ERR_MISSING;
        res_next.last = 1'b1;
        // back to the reset parse state
        fp_next = FP_COUNT; tp_next = TP_IDLE; acc_next = '0; li_next = '0;
        tc_next = '0; prev_next = '0; quoted_next = 1'b0; err_next = ERR_NONE;
        bc_next = '0; cur_start_next = '0; cur_ctl_next = '0; cur_sess_next = 1'b0;
        nl_next = '0; crp_next = 1'b0; als_next = 1'b1;
      end
      default: ;
    endcase
    // side effects of a completed number
    if (fin_apply) begin
      case (fp)
        FP_COUNT: tc_next = acc[6:0];
        FP_ADDR: begin
          cur_start_next = s_sum[23:0];
          cur_sess_next  = acc >= HIGH_AREA_LBA;
        end
        FP_CTRL: cur_ctl_next = acc[2:0];
        default: ;
      endcase
    end
    // first error wins
    if (fail != ERR_NONE && err == ERR_NONE) err_next = fail;
  end

  // control and parse registers
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_sector_bytes  <= RAW_SECTOR_RST;
      max_frame_address <= MAX_FRAME_RST;
      fp <= FP_COUNT; tp <= TP_IDLE; acc <= '0; li <= '0; tc <= '0; prev <= '0;
      quoted <= 1'b0; err <= ERR_NONE; bc <= '0; cur_start <= '0; cur_ctl <= '0;
      cur_sess <= 1'b0; nl <= '0; crp <= 1'b0; als <= 1'b1;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RAW_SECTOR: raw_sector_bytes  <= cfg_data[15:0];
          REG_MAX_FRAME:  max_frame_address <= cfg_data;
          default: ;
        endcase
      end
      fp <= fp_next; tp <= tp_next; acc <= acc_next; li <= li_next; tc <= tc_next;
      prev <= prev_next; quoted <= quoted_next; err <= err_next; bc <= bc_next;
      cur_start <= cur_start_next; cur_ctl <= cur_ctl_next; cur_sess <= cur_sess_next;
      nl <= nl_next; crp <= crp_next; als <= als_next;
      if (emit) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.cmd == CMD_ACCEPT) begin
      byte_reg <= data_byte;
      last_reg <= last_byte;
    end
    ch      <= ch_next;
    first_c <= first_c_next;
    last_c  <= last_c_next;
    wi      <= wi_next;
    wk      <= wk_next;
    if (emit) res <= res_next;
  end

  // name store, two registered read ports for the compare walk
  always_ff @(posedge clk) begin
    if (store_we) name_store[store_waddr] <= ch;
    ca_q <= name_store[{wi[TW-1:0], wk}];
    cb_q <= name_store[{idx[TW-1:0], wk}];
  end

  // name lengths
  always_ff @(posedge clk) begin
    if (lens_we) name_lengths[idx[TW-1:0]] <= nl;
    len_q <= name_lengths[wi[TW-1:0]];
  end

endmodule

### hdl/disc_track_sheet_line_parser.sv
// ----------------------------------------------------------------------------
// disc_track_sheet_line_parser
// Byte-wise track sheet checker emitting name characters, track records and
// a final verdict.
//
//   channel     dir  transfer condition          payload
//   byte_in     in   valid & ready               data_byte, last_byte
//   result_out  out  valid & ready               kind .. last
//   cfg         in   cfg_we (no handshake)       cfg_index, cfg_data
//
// A byte passes through accept, entry check, a character or line step and
// finish; a carriage return held back for the next byte skips the step.
// A name end adds a walk over earlier names in the name length memory:
// each earlier name takes a length read and check, an equal-length name
// adds a read and compare per character, and a final step closes the walk.
// The last byte adds a line end step, if one is missing, and the verdict.
// Reset is synchronous; no clearing pass is needed.
// A full result register holds the character, line and verdict steps, even
// when they emit nothing; the entry check and the name walk do not wait.
// ----------------------------------------------------------------------------
module disc_track_sheet_line_parser #(
  parameter int MAX_TRACKS      = dtsl_pkg::MAX_TRACKS_DEF,
  parameter int NAME_CAPACITY   = dtsl_pkg::NAME_CAPACITY_DEF,
  parameter int MAX_SHEET_BYTES = dtsl_pkg::MAX_SHEET_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  dtsl_in_if.sink                        byte_in,
  dtsl_out_if.source                     result_out,
  input  logic                           cfg_we,
  input  logic [dtsl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dtsl_pkg::CFG_W-1:0]     cfg_data
);
  import dtsl_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  res_t  res;
  logic  res_valid;
  logic  in_ready;

  // sequencer
  dtsl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_in.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // datapath
  dtsl_dp #(
    .MAX_TRACKS      (MAX_TRACKS),
    .NAME_CAPACITY   (NAME_CAPACITY),
    .MAX_SHEET_BYTES (MAX_SHEET_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .data_byte (byte_in.data_byte),
    .last_byte (byte_in.last_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_ready (result_out.ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // channel wiring
  assign byte_in.ready           = in_ready;
  assign result_out.valid        = res_valid;
  assign result_out.kind         = res.kind;
  assign result_out.name_char    = res.name_char;
  assign result_out.track_number = res.track_number;
  assign result_out.control_bits = res.control_bits;
  assign result_out.session_high = res.session_high;
  assign result_out.start_frame  = res.start_frame;
  assign result_out.sheet_ok     = res.sheet_ok;
  assign result_out.error_code   = res.error_code;
  assign result_out.last         = res.last;

endmodule
